>>> hw/rtl/tws_pkg.sv
`default_nettype none
package tws_pkg;

  localparam int DATA_BITS = 8;
  localparam int ADDR_BITS = 16;
  localparam int FRAME_BITS = 2 * DATA_BITS + ADDR_BITS;
  localparam int READ_FRAME_BITS = ADDR_BITS + DATA_BITS;
  localparam int BIT_CNT_W = $clog2(FRAME_BITS + 1);
  localparam int RD_CNT_W = $clog2(DATA_BITS + 1);
  localparam int IN_DATA_W = 40;
  localparam int OUT_DATA_W = 16;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ = 2'd1;
  localparam logic [1:0] REQ_SAMPLE = 2'd2;

  typedef enum logic [1:0] {
    SLOT_TURN_OUT = 2'd0,
    SLOT_DRIVEN = 2'd1,
    SLOT_TURN_IN = 2'd2,
    SLOT_SAMPLE = 2'd3
  } slot_kind_t;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ = 2'd1,
    OP_SAMPLE = 2'd2
  } op_t;

  typedef struct packed {
    op_t op;
    logic [FRAME_BITS-1:0] frame;
    logic [DATA_BITS-1:0] rbyte;
    logic rdone;
  } cmd_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_BITS = 2'd1,
    B_TURN_IN = 2'd2
  } back_state_t;

endpackage
`default_nettype wire

>>> hw/rtl/two_wire_serial_master.sv
// Master for a serial link with one data pin and one clock pin.
// The input channel (s_*) takes requests: s_tuser selects a write, a read or a
// line sample, and s_tdata carries the write byte, address, command byte and
// sampled line level. The output channel (m_*) gives one item per pin slot,
// with the slot kind in m_tuser and m_tlast on the final slot of a request.
// A write gives 33 slots and a read 26 slots, one slot per cycle while the
// receiver keeps m_tready high; a line sample during a read gives one slot,
// and the eighth sample carries the assembled byte with read_done set.
// An accepted request is written into the command queue and is taken from
// it into the output register when the back end is free. The shift-out
// counter of the back end paces the slots of a write or a read.
// A two-entry command queue sits between the request decoder and the slot
// sequencer, so requests are accepted while slots are still being sent.
// When the receiver stalls, the output item holds, the sequencer waits and
// the queue fills, after which s_tready drops.
// Reset clears the queue, the pending read and the output valid.
`default_nettype none
module two_wire_serial_master (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_tvalid,
  output logic s_tready,
  // [7:0] write_byte, [23:8] target_address, [31:24] command_byte,
  // [32] line_level, [39:33] zero
  input wire logic [tws_pkg::IN_DATA_W-1:0] s_tdata,
  // [1:0] req_type
  input wire logic [1:0] s_tuser,
  output logic m_tvalid,
  input wire logic m_tready,
  // [0] pin_level, [1] pin_drive_enable, [2] clock_first_level,
  // [10:3] read_byte, [11] read_done, [15:12] zero
  output logic [tws_pkg::OUT_DATA_W-1:0] m_tdata,
  // [1:0] slot_kind
  output logic [1:0] m_tuser,
  output logic m_tlast
);

  logic accept;
  logic push;
  logic full;
  logic pop;
  logic empty;
  tws_pkg::cmd_t push_cmd;
  tws_pkg::cmd_t head;

  assign s_tready = !full;
  assign accept = s_tvalid && s_tready;

  tws_front u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .req_type(s_tuser),
    .write_byte(s_tdata[7:0]),
    .target_address(s_tdata[23:8]),
    .command_byte(s_tdata[31:24]),
    .line_level(s_tdata[32]),
    .push(push),
    .push_cmd(push_cmd)
  );

  tws_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_cmd(push_cmd),
    .full(full),
    .pop(pop),
    .empty(empty),
    .head(head)
  );

  tws_back u_back (
    .clk(clk),
    .rst(rst),
    .empty(empty),
    .head(head),
    .pop(pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

endmodule
`default_nettype wire

>>> hw/rtl/tws_front.sv
`default_nettype none
module tws_front (
  input wire logic clk,
  input wire logic rst,
  input wire logic accept,
  input wire logic [1:0] req_type,
  input wire logic [tws_pkg::DATA_BITS-1:0] write_byte,
  input wire logic [tws_pkg::ADDR_BITS-1:0] target_address,
  input wire logic [tws_pkg::DATA_BITS-1:0] command_byte,
  input wire logic line_level,
  output logic push,
  output tws_pkg::cmd_t push_cmd
);

  logic awaiting;
  logic awaiting_next;
  logic [tws_pkg::RD_CNT_W-1:0] rcount;
  logic [tws_pkg::RD_CNT_W-1:0] rcount_next;
  logic [tws_pkg::DATA_BITS-1:0] rshift;
  logic [tws_pkg::DATA_BITS-1:0] rshift_next;
  logic [tws_pkg::DATA_BITS-1:0] rshift_sum;

  always_comb begin
    rshift_sum = rshift | (tws_pkg::DATA_BITS'(line_level) << rcount);
    awaiting_next = awaiting;
    rcount_next = rcount;
    rshift_next = rshift;
    push = 1'b0;
    push_cmd.op = tws_pkg::OP_SAMPLE;
    push_cmd.frame = '0;
    push_cmd.rbyte = '0;
    push_cmd.rdone = 1'b0;
    if (accept) begin
      case (req_type)
        tws_pkg::REQ_WRITE: begin
          push = 1'b1;
          push_cmd.op = tws_pkg::OP_WRITE;
          push_cmd.frame = {command_byte, target_address, write_byte};
          awaiting_next = 1'b0;
          rcount_next = '0;
          rshift_next = '0;
        end
        tws_pkg::REQ_READ: begin
          push = 1'b1;
          push_cmd.op = tws_pkg::OP_READ;
          push_cmd.frame = tws_pkg::FRAME_BITS'({command_byte, target_address});
          awaiting_next = 1'b1;
          rcount_next = '0;
          rshift_next = '0;
        end
        tws_pkg::REQ_SAMPLE: begin
          if (awaiting) begin
            push = 1'b1;
            push_cmd.op = tws_pkg::OP_SAMPLE;
            if (rcount == tws_pkg::RD_CNT_W'(tws_pkg::DATA_BITS - 1)) begin
              push_cmd.rbyte = rshift_sum;
              push_cmd.rdone = 1'b1;
              awaiting_next = 1'b0;
              rcount_next = '0;
              rshift_next = '0;
            end else begin
              rcount_next = rcount + 1'b1;
              rshift_next = rshift_sum;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting <= 1'b0;
      rcount <= '0;
      rshift <= '0;
    end else begin
      awaiting <= awaiting_next;
      rcount <= rcount_next;
      rshift <= rshift_next;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/tws_queue.sv
`default_nettype none
module tws_queue (
  input wire logic clk,
  input wire logic rst,
  input wire logic push,
  input wire tws_pkg::cmd_t push_cmd,
  output logic full,
  input wire logic pop,
  output logic empty,
  output tws_pkg::cmd_t head
);

  tws_pkg::cmd_t slots [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/tws_back.sv
`default_nettype none
module tws_back (
  input wire logic clk,
  input wire logic rst,
  input wire logic empty,
  input wire tws_pkg::cmd_t head,
  output logic pop,
  output logic m_tvalid,
  input wire logic m_tready,
  output logic [tws_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [1:0] m_tuser,
  output logic m_tlast
);

  tws_pkg::back_state_t state;
  tws_pkg::back_state_t state_next;
  tws_pkg::op_t op;
  tws_pkg::op_t op_next;
  logic [tws_pkg::FRAME_BITS-1:0] shift;
  logic [tws_pkg::FRAME_BITS-1:0] shift_next;
  logic [tws_pkg::BIT_CNT_W-1:0] count;
  logic [tws_pkg::BIT_CNT_W-1:0] count_next;
  logic out_free;
  logic emit;

  tws_pkg::slot_kind_t kind_next;
  logic pin_next;
  logic drive_next;
  logic clk_first_next;
  logic [tws_pkg::DATA_BITS-1:0] byte_next;
  logic done_next;
  logic last_next;

  tws_pkg::slot_kind_t kind;
  logic pin;
  logic drive;
  logic clk_first;
  logic [tws_pkg::DATA_BITS-1:0] rbyte;
  logic done;
  logic last;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    op_next = op;
    shift_next = shift;
    count_next = count;
    pop = 1'b0;
    emit = 1'b0;
    kind_next = tws_pkg::SLOT_TURN_OUT;
    pin_next = 1'b0;
    drive_next = 1'b1;
    clk_first_next = 1'b1;
    byte_next = '0;
    done_next = 1'b0;
    last_next = 1'b0;
    case (state)
      tws_pkg::B_IDLE: begin
        if (!empty && out_free) begin
          pop = 1'b1;
          emit = 1'b1;
          if (head.op == tws_pkg::OP_SAMPLE) begin
            kind_next = tws_pkg::SLOT_SAMPLE;
            drive_next = 1'b0;
            clk_first_next = 1'b1;
            byte_next = head.rbyte;
            done_next = head.rdone;
            last_next = 1'b1;
          end else begin
            kind_next = tws_pkg::SLOT_TURN_OUT;
            op_next = head.op;
            shift_next = head.frame;
            count_next = (head.op == tws_pkg::OP_WRITE) ?
                         tws_pkg::BIT_CNT_W'(tws_pkg::FRAME_BITS) :
                         tws_pkg::BIT_CNT_W'(tws_pkg::READ_FRAME_BITS);
            state_next = tws_pkg::B_BITS;
          end
        end
      end
      tws_pkg::B_BITS: begin
        if (out_free) begin
          emit = 1'b1;
          kind_next = tws_pkg::SLOT_DRIVEN;
          pin_next = shift[0];
          clk_first_next = 1'b0;
          shift_next = shift >> 1;
          count_next = count - 1'b1;
          if (count == tws_pkg::BIT_CNT_W'(1)) begin
            if (op == tws_pkg::OP_WRITE) begin
              last_next = 1'b1;
              state_next = tws_pkg::B_IDLE;
            end else begin
              state_next = tws_pkg::B_TURN_IN;
            end
          end
        end
      end
      tws_pkg::B_TURN_IN: begin
        if (out_free) begin
          emit = 1'b1;
          kind_next = tws_pkg::SLOT_TURN_IN;
          drive_next = 1'b0;
          clk_first_next = 1'b0;
          last_next = 1'b1;
          state_next = tws_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = tws_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tws_pkg::B_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op <= op_next;
    shift <= shift_next;
    count <= count_next;
    if (emit) begin
      kind <= kind_next;
      pin <= pin_next;
      drive <= drive_next;
      clk_first <= clk_first_next;
      rbyte <= byte_next;
      done <= done_next;
      last <= last_next;
    end
  end

  assign m_tuser = kind;
  assign m_tlast = last;
  assign m_tdata = tws_pkg::OUT_DATA_W'({done, rbyte, clk_first, drive, pin});

endmodule
`default_nettype wire

>>> verif/tb.sv
`default_nettype none
module tb;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 360;
  localparam int IDLE_LIMIT = 1000;
  localparam int TAIL_CYCLES = 60;

  typedef struct packed {
    tws_pkg::slot_kind_t kind;
    logic pin_level;
    logic drive_en;
    logic clk_first;
    logic [tws_pkg::DATA_BITS-1:0] rbyte;
    logic rdone;
    logic last;
  } pin_slot_t;

  typedef struct {
    logic [1:0] req;
    logic [tws_pkg::IN_DATA_W-1:0] data;
  } request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [tws_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = tws_pkg::REQ_WRITE;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [tws_pkg::OUT_DATA_W-1:0] m_tdata;
  logic [1:0] m_tuser;
  logic m_tlast;

  request_t request_q[$];
  pin_slot_t slot_expect_q[$];

  int req_accept_cnt = 0;
  int req_popped_cnt = 0;
  int slot_cnt = 0;
  int errors = 0;
  int burst_left = 4;
  int gap_left = 0;
  int ready_run = 0;
  int ready_mode = 0;
  int ready_phase = 0;

  // Predictor state for the pending read.
  logic rd_waiting = 1'b0;
  logic [tws_pkg::RD_CNT_W-1:0] rd_count = '0;
  logic [tws_pkg::DATA_BITS-1:0] rd_shift = '0;

  two_wire_serial_master i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string field, input int got, input int want);
    errors++;
    $display("mismatch on item %0d, %s: got %0h, expected %0h", slot_cnt, field, got, want);
  endtask

  function automatic void push_slot(input tws_pkg::slot_kind_t kind, input logic pin,
                                    input logic drive, input logic clkf,
                                    input logic [tws_pkg::DATA_BITS-1:0] rbyte,
                                    input logic rdone, input logic last);
    pin_slot_t s;
    s.kind = kind;
    s.pin_level = pin;
    s.drive_en = drive;
    s.clk_first = clkf;
    s.rbyte = rbyte;
    s.rdone = rdone;
    s.last = last;
    slot_expect_q.push_back(s);
  endfunction

  task automatic predict_slots(input logic [1:0] req,
                               input logic [tws_pkg::IN_DATA_W-1:0] data);
    logic [tws_pkg::DATA_BITS-1:0] wbyte;
    logic [tws_pkg::ADDR_BITS-1:0] addr;
    logic [tws_pkg::DATA_BITS-1:0] cmd;
    logic line;
    int i;
    wbyte = data[tws_pkg::DATA_BITS-1:0];
    addr = data[tws_pkg::DATA_BITS+tws_pkg::ADDR_BITS-1:tws_pkg::DATA_BITS];
    cmd = data[2*tws_pkg::DATA_BITS+tws_pkg::ADDR_BITS-1:tws_pkg::DATA_BITS+tws_pkg::ADDR_BITS];
    line = data[2*tws_pkg::DATA_BITS+tws_pkg::ADDR_BITS];
    if (req == tws_pkg::REQ_WRITE || req == tws_pkg::REQ_READ) begin
      rd_waiting = 1'b0;
      rd_count = '0;
      rd_shift = '0;
      push_slot(tws_pkg::SLOT_TURN_OUT, 1'b0, 1'b1, 1'b1, '0, 1'b0, 1'b0);
      if (req == tws_pkg::REQ_WRITE) begin
        for (i = 0; i < tws_pkg::DATA_BITS; i++) begin
          push_slot(tws_pkg::SLOT_DRIVEN, wbyte[i], 1'b1, 1'b0, '0, 1'b0, 1'b0);
        end
      end
      for (i = 0; i < tws_pkg::ADDR_BITS; i++) begin
        push_slot(tws_pkg::SLOT_DRIVEN, addr[i], 1'b1, 1'b0, '0, 1'b0, 1'b0);
      end
      for (i = 0; i < tws_pkg::DATA_BITS; i++) begin
        push_slot(tws_pkg::SLOT_DRIVEN, cmd[i], 1'b1, 1'b0, '0, 1'b0,
                  (req == tws_pkg::REQ_WRITE) && (i == tws_pkg::DATA_BITS - 1));
      end
      if (req == tws_pkg::REQ_READ) begin
        push_slot(tws_pkg::SLOT_TURN_IN, 1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b1);
        rd_waiting = 1'b1;
      end
    end else if (req == tws_pkg::REQ_SAMPLE && rd_waiting) begin
      rd_shift = rd_shift | (tws_pkg::DATA_BITS'(line) << rd_count);
      rd_count = rd_count + 1'b1;
      if (rd_count >= tws_pkg::RD_CNT_W'(tws_pkg::DATA_BITS)) begin
        push_slot(tws_pkg::SLOT_SAMPLE, 1'b0, 1'b0, 1'b1, rd_shift, 1'b1, 1'b1);
        rd_waiting = 1'b0;
        rd_count = '0;
        rd_shift = '0;
      end else begin
        push_slot(tws_pkg::SLOT_SAMPLE, 1'b0, 1'b0, 1'b1, '0, 1'b0, 1'b1);
      end
    end
  endtask

  task automatic queue_item(input logic [1:0] req, input logic [tws_pkg::DATA_BITS-1:0] wbyte,
                            input logic [tws_pkg::ADDR_BITS-1:0] addr,
                            input logic [tws_pkg::DATA_BITS-1:0] cmd, input logic line);
    request_t r;
    r.req = req;
    r.data = '0;
    r.data[2*tws_pkg::DATA_BITS+tws_pkg::ADDR_BITS:0] = {line, cmd, addr, wbyte};
    request_q.push_back(r);
  endtask

  task automatic queue_random(input logic [1:0] req);
    queue_item(req, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
               8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic queue_read_samples(input int n, input bit with_noise);
    int i;
    queue_random(tws_pkg::REQ_READ);
    for (i = 0; i < n; i++) begin
      if (with_noise && $urandom_range(0, 9) == 0) queue_random(REQ_UNUSED);
      queue_random(tws_pkg::REQ_SAMPLE);
    end
  endtask

  always @(negedge clk) begin
    logic hold;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      hold = s_tvalid;
      if (req_popped_cnt < req_accept_cnt) begin
        void'(request_q.pop_front());
        req_popped_cnt++;
        hold = 1'b0;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end
      end
      if (!hold) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (request_q.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tuser <= request_q[0].req;
          s_tdata <= request_q[0].data;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (ready_run == 0) begin
      ready_run = $urandom_range(10, 200);
      ready_mode = $urandom_range(0, 3);
    end
    ready_run--;
    ready_phase++;
    case (ready_mode)
      0: begin
        m_tready <= 1'b1;
      end
      1: begin
        m_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        m_tready <= (ready_phase % 4 == 0);
      end
      default: begin
        m_tready <= (ready_phase % 7 != 3) && (ready_phase % 7 != 4);
      end
    endcase
  end

  always @(posedge clk) begin
    pin_slot_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (slot_expect_q.size() == 0) begin
          report_mismatch("item with nothing expected, kind", m_tuser, 0);
        end else begin
          want = slot_expect_q.pop_front();
          if (m_tuser !== want.kind) report_mismatch("slot_kind", m_tuser, want.kind);
          if (m_tdata[0] !== want.pin_level) begin
            report_mismatch("pin_level", m_tdata[0], want.pin_level);
          end
          if (m_tdata[1] !== want.drive_en) begin
            report_mismatch("pin_drive_enable", m_tdata[1], want.drive_en);
          end
          if (m_tdata[2] !== want.clk_first) begin
            report_mismatch("clock_first_level", m_tdata[2], want.clk_first);
          end
          if (m_tdata[10:3] !== want.rbyte) begin
            report_mismatch("read_byte", m_tdata[10:3], want.rbyte);
          end
          if (m_tdata[11] !== want.rdone) report_mismatch("read_done", m_tdata[11], want.rdone);
          if (m_tdata[15:12] !== 4'd0) report_mismatch("tdata padding", m_tdata[15:12], 0);
          if (m_tlast !== want.last) report_mismatch("last", m_tlast, want.last);
        end
        slot_cnt++;
      end
      if (s_tvalid && s_tready) begin
        predict_slots(s_tuser, s_tdata);
        req_accept_cnt++;
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb: errors");
    $finish;
  end

  initial begin
    int sel;
    queue_item(tws_pkg::REQ_WRITE, 8'h00, 16'h0000, 8'h00, 1'b0);
    queue_item(tws_pkg::REQ_WRITE, 8'hFF, 16'hFFFF, 8'hFF, 1'b1);
    queue_item(tws_pkg::REQ_WRITE, 8'h01, 16'h0001, 8'h01, 1'b0);
    queue_item(tws_pkg::REQ_READ, 8'hFF, 16'hFFFF, 8'hFF, 1'b1);
    repeat (tws_pkg::DATA_BITS) queue_item(tws_pkg::REQ_SAMPLE, 8'h00, 16'h0000, 8'h00, 1'b1);
    queue_item(tws_pkg::REQ_SAMPLE, 8'hFF, 16'hFFFF, 8'hFF, 1'b1);
    queue_item(REQ_UNUSED, 8'hA5, 16'h5A5A, 8'hC3, 1'b1);
    queue_item(tws_pkg::REQ_READ, 8'h00, 16'h0000, 8'h00, 1'b0);
    queue_item(tws_pkg::REQ_SAMPLE, 8'h00, 16'h0000, 8'h00, 1'b1);
    queue_item(tws_pkg::REQ_SAMPLE, 8'h00, 16'h0000, 8'h00, 1'b0);
    queue_item(tws_pkg::REQ_WRITE, 8'h80, 16'h8000, 8'h80, 1'b0);
    queue_item(tws_pkg::REQ_READ, 8'h00, 16'h1234, 8'hA5, 1'b0);
    queue_item(tws_pkg::REQ_SAMPLE, 8'h00, 16'h0000, 8'h00, 1'b0);
    queue_item(tws_pkg::REQ_SAMPLE, 8'h00, 16'h0000, 8'h00, 1'b1);
    queue_item(tws_pkg::REQ_SAMPLE, 8'h00, 16'h0000, 8'h00, 1'b0);
    queue_item(REQ_UNUSED, 8'h00, 16'h0000, 8'h00, 1'b0);
    queue_item(tws_pkg::REQ_SAMPLE, 8'h00, 16'h0000, 8'h00, 1'b1);
    queue_item(tws_pkg::REQ_SAMPLE, 8'h00, 16'h0000, 8'h00, 1'b1);
    queue_item(tws_pkg::REQ_SAMPLE, 8'h00, 16'h0000, 8'h00, 1'b0);
    queue_item(tws_pkg::REQ_SAMPLE, 8'h00, 16'h0000, 8'h00, 1'b1);
    queue_item(tws_pkg::REQ_SAMPLE, 8'h00, 16'h0000, 8'h00, 1'b1);

    while (request_q.size() < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        queue_read_samples(tws_pkg::DATA_BITS, 1'b1);
      end else if (sel < 70) begin
        queue_random(tws_pkg::REQ_WRITE);
      end else if (sel < 85) begin
        queue_read_samples($urandom_range(0, tws_pkg::DATA_BITS - 1), 1'b1);
      end else if (sel < 92) begin
        queue_random(REQ_UNUSED);
        queue_random(tws_pkg::REQ_SAMPLE);
      end else begin
        queue_item(2'($urandom_range(0, 1)), {8{sel[0]}}, {16{sel[1]}}, {8{sel[2]}}, sel[3]);
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (request_q.size() != 0) @(posedge clk);
    while (slot_expect_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
hw/rtl/tws_pkg.sv
hw/rtl/tws_front.sv
hw/rtl/tws_queue.sv
hw/rtl/tws_back.sv
hw/rtl/two_wire_serial_master.sv
verif/tb.sv
